// File: src/tcpu_pkg.sv
package tcpu_pkg;

	localparam int REG_COUNT = 16;
	localparam int MEM_DEPTH = 256;
	localparam int DATA_W    = 8;
	localparam int REG_AW    = $clog2(REG_COUNT);
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int INSTR_W   = 16;
	localparam int RESULT_W  = 21;
	localparam int TDATA_OUT_W = 24;

	typedef enum logic [3:0] {
		OP_LOAD_MEM = 4'd1,
		OP_LOAD_IMM = 4'd2,
		OP_STORE    = 4'd3,
		OP_MOVE     = 4'd4,
		OP_ADD      = 4'd5,
		OP_NOP      = 4'd6,
		OP_JUMP_EQ  = 4'd11,
		OP_HALT     = 4'd12
	} opcode_t;

	typedef struct packed {
		logic [DATA_W-1:0] written_value;
		logic              wrote_memory;
		logic              wrote_register;
		logic              illegal;
		logic [MEM_AW-1:0] jump_target;
		logic              jump_taken;
		logic              halted;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [REG_AW-1:0] addr;
		logic [DATA_W-1:0] data;
	} reg_write_t;

	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] addr;
		logic [DATA_W-1:0] data;
	} mem_write_t;

endpackage

// File: src/tcpu_ram.sv
module tcpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/teaching_cpu_instruction_execute.sv
// Instruction execute unit of a small teaching machine: each transfer on the slave stream
// carries one 16-bit instruction (opcode, R, X, Y nibbles), and each instruction yields
// exactly one result transfer on the master stream describing what it did (halt, taken
// jump and its target, illegal opcode, register or memory write and the byte written).
// The sixteen 8-bit registers and 256 bytes of data memory live in synchronous RAMs. After
// reset a clearing pass zeroes them one entry per cycle, and s_axis_tready stays low until
// it is done. The instruction is held in the stage 1 register while the RAMs are read, and
// its result goes into the output register, which drives result valid. The unit sustains
// one instruction per cycle while the master side takes results, set by the single
// read-modify-write pass through the register and data RAMs, with write-to-read forwarding
// covering back-to-back dependent instructions. Backpressure on the master side stalls
// stage 1 and then the slave side.
module teaching_cpu_instruction_execute (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [15:0] instruction
	input  logic [tcpu_pkg::INSTR_W-1:0]     s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] halted, [1] jump_taken, [9:2] jump_target, [10] illegal,
	// [11] wrote_register, [12] wrote_memory, [20:13] written_value, [23:21] zero
	output logic [tcpu_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

	localparam int AW = tcpu_pkg::REG_AW;
	localparam int MW = tcpu_pkg::MEM_AW;
	localparam int DW = tcpu_pkg::DATA_W;

	// decode of the incoming word
	logic [3:0]    in_op;
	logic [AW-1:0] in_r, in_x, in_y;
	logic [MW-1:0] in_xy;
	logic [AW-1:0] in_rda, in_rdb;
	logic          accept;

	// stage 1: instruction waiting on its RAM reads
	logic              valid_s1;
	logic [3:0]        op_s1;
	logic [AW-1:0]     r_s1, y_s1;
	logic [MW-1:0]     xy_s1;
	logic [AW-1:0]     rda_addr_s1, rdb_addr_s1;

	// RAM read data
	logic [DW-1:0] rda_raw, rdb_raw, mem_raw;
	logic [DW-1:0] rda_val, rdb_val, mem_val;

	// clearing pass after reset
	logic          clearing_q;
	logic [MW-1:0] clr_addr_q;

	// RAM write ports
	logic          reg_we, mem_we;
	logic [AW-1:0] reg_waddr;
	logic [MW-1:0] mem_waddr;
	logic [DW-1:0] reg_wdata, mem_wdata;

	// most recent writes, forwarded to a read issued at the same edge
	tcpu_pkg::reg_write_t last_reg_q, reg_wr;
	tcpu_pkg::mem_write_t last_mem_q, mem_wr;

	// output register
	logic              out_valid_q;
	tcpu_pkg::result_t out_q, res;
	logic              exec;

	assign in_op = s_axis_tdata[15:12];
	assign in_r  = s_axis_tdata[11:8];
	assign in_x  = s_axis_tdata[7:4];
	assign in_y  = s_axis_tdata[3:0];
	assign in_xy = s_axis_tdata[7:0];

	// port A serves R for store and compare, X otherwise; port B serves register 0
	// for compare, Y otherwise
	always_comb begin
		if (in_op == tcpu_pkg::OP_STORE || in_op == tcpu_pkg::OP_JUMP_EQ) begin
			in_rda = in_r;
		end else begin
			in_rda = in_x;
		end
		if (in_op == tcpu_pkg::OP_JUMP_EQ) begin
			in_rdb = '0;
		end else begin
			in_rdb = in_y;
		end
	end

	// execute when stage 1 holds an instruction and the output slot frees up
	assign exec          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !clearing_q && (!valid_s1 || exec);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// during the clearing pass write zeros, afterwards take the executed writes
	always_comb begin
		if (clearing_q) begin
			reg_we    = 1'b1;
			reg_waddr = clr_addr_q[AW-1:0];
			reg_wdata = '0;
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			reg_we    = reg_wr.we;
			reg_waddr = reg_wr.addr;
			reg_wdata = reg_wr.data;
			mem_we    = mem_wr.we;
			mem_waddr = mem_wr.addr;
			mem_wdata = mem_wr.data;
		end
	end

	// two copies of the register file give two read ports
	tcpu_ram #(.WIDTH(DW), .DEPTH(tcpu_pkg::REG_COUNT)) u_reg_a (
		.clk   (clk),
		.we    (reg_we),
		.waddr (reg_waddr),
		.wdata (reg_wdata),
		.re    (accept),
		.raddr (in_rda),
		.rdata (rda_raw)
	);

	tcpu_ram #(.WIDTH(DW), .DEPTH(tcpu_pkg::REG_COUNT)) u_reg_b (
		.clk   (clk),
		.we    (reg_we),
		.waddr (reg_waddr),
		.wdata (reg_wdata),
		.re    (accept),
		.raddr (in_rdb),
		.rdata (rdb_raw)
	);

	tcpu_ram #(.WIDTH(DW), .DEPTH(tcpu_pkg::MEM_DEPTH)) u_dmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (in_xy),
		.rdata (mem_raw)
	);

	// resolve read data: forward the latest write on an address match
	always_comb begin
		if (last_reg_q.we && last_reg_q.addr == rda_addr_s1) begin
			rda_val = last_reg_q.data;
		end else begin
			rda_val = rda_raw;
		end
		if (last_reg_q.we && last_reg_q.addr == rdb_addr_s1) begin
			rdb_val = last_reg_q.data;
		end else begin
			rdb_val = rdb_raw;
		end
		if (last_mem_q.we && last_mem_q.addr == xy_s1) begin
			mem_val = last_mem_q.data;
		end else begin
			mem_val = mem_raw;
		end
	end

	// execute the instruction in stage 1
	always_comb begin
		res    = '0;
		reg_wr = '0;
		mem_wr = '0;
		case (op_s1)
			tcpu_pkg::OP_LOAD_MEM: begin
				reg_wr = '{we: 1'b1, addr: r_s1, data: mem_val};
			end
			tcpu_pkg::OP_LOAD_IMM: begin
				reg_wr = '{we: 1'b1, addr: r_s1, data: xy_s1};
			end
			tcpu_pkg::OP_STORE: begin
				mem_wr = '{we: 1'b1, addr: xy_s1, data: rda_val};
			end
			tcpu_pkg::OP_MOVE: begin
				reg_wr = '{we: 1'b1, addr: y_s1, data: rda_val};
			end
			tcpu_pkg::OP_ADD: begin
				// carry out of the top bit drops
				reg_wr = '{we: 1'b1, addr: r_s1, data: DW'(rda_val + rdb_val)};
			end
			tcpu_pkg::OP_NOP: begin
				res = '0;
			end
			tcpu_pkg::OP_JUMP_EQ: begin
				if (rda_val == rdb_val) begin
					res.jump_taken  = 1'b1;
					res.jump_target = xy_s1;
				end
			end
			tcpu_pkg::OP_HALT: begin
				res.halted = 1'b1;
			end
			default: begin
				res.illegal = 1'b1;
			end
		endcase
		res.wrote_register = reg_wr.we;
		res.wrote_memory   = mem_wr.we;
		if (reg_wr.we) begin
			res.written_value = reg_wr.data;
		end else if (mem_wr.we) begin
			res.written_value = mem_wr.data;
		end
		// gate the writes so a stalled instruction changes nothing
		reg_wr.we = reg_wr.we && exec;
		mem_wr.we = mem_wr.we && exec;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			last_reg_q  <= '0;
			last_mem_q  <= '0;
		end else begin
			// advance the clearing pass one entry per cycle, drop it after the last
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == MW'(tcpu_pkg::MEM_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (exec) begin
				valid_s1 <= 1'b0;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			// record the writes of the instruction just executed; hold otherwise
			if (exec) begin
				last_reg_q <= reg_wr;
				last_mem_q <= mem_wr;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= in_op;
			r_s1        <= in_r;
			y_s1        <= in_y;
			xy_s1       <= in_xy;
			rda_addr_s1 <= in_rda;
			rdb_addr_s1 <= in_rdb;
		end
		if (exec) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(tcpu_pkg::TDATA_OUT_W - tcpu_pkg::RESULT_W)'(0), out_q};

endmodule
